FILE: src/fab_pkg.sv
// ============================================================================
// fab_pkg: shared constants for the fragment acknowledgement bitmap encoder
// Holds field widths, header constants and the default window size.
// ============================================================================
package fab_pkg;

  // Fixed widths of the transaction fields.
  localparam int WINDOW_W = 2;
  localparam int BITMAP_W = 63;
  localparam int BYTE_W   = 8;

  // Default number of bitmap elements in one window.
  localparam int TILE_COUNT_DEFAULT = 63;

  // Header byte used when every tile of the window was received.
  localparam logic [BYTE_W-1:0] HDR_W_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] HDR_C_BIT   = 8'h20;
  localparam int                HDR_W_SHIFT = 6;

  // Bits in front of the bitmap in the long form: w1, w0 and a zero C bit.
  localparam int HDR_BITS = 3;

endpackage

FILE: src/fab_encode.sv
// ============================================================================
// fab_encode: acknowledgement frame builder
// Turns one request into a left-aligned bit stream and its byte count.
// ============================================================================
module fab_encode
  import fab_pkg::*;
#(
  parameter int  TILE_COUNT   = TILE_COUNT_DEFAULT,
  localparam int STREAM_BYTES = (TILE_COUNT + HDR_BITS) / 8 + 1,
  localparam int STREAM_W     = STREAM_BYTES * BYTE_W,
  localparam int CNT_W        = $clog2(STREAM_BYTES + 1)
) (
  input  logic [WINDOW_W-1:0] window,
  input  logic                all_received,
  input  logic                compress,
  input  logic [BITMAP_W-1:0] bitmap,
  output logic [STREAM_W-1:0] stream,
  output logic [CNT_W-1:0]    nbytes
);

  localparam int IDX_W  = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int KEPT_W = $clog2(TILE_COUNT + 1);
  localparam int TOT_W  = $clog2(TILE_COUNT + HDR_BITS + 1);
  localparam int PAD_W  = STREAM_W - HDR_BITS - TILE_COUNT;

  logic [TILE_COUNT-1:0] bm;
  logic [TILE_COUNT-1:0] zero_bits;
  logic [TILE_COUNT-1:0] neg;
  logic [TILE_COUNT-1:0] lowest;
  logic [TILE_COUNT-1:0] keep;
  logic [IDX_W-1:0]      low_idx;
  logic [KEPT_W-1:0]     kept;
  logic [TOT_W-1:0]      total;
  logic [STREAM_W-1:0]   raw;
  logic [STREAM_W-1:0]   mask;
  logic [STREAM_W-1:0]   fill;
  logic [BYTE_W-1:0]     hdr;

  always_comb begin
    bm        = bitmap[TILE_COUNT-1:0];
    zero_bits = ~bm;
    // Two's complement isolates the lowest zero bitmap bit, which is the
    // last zero element; everything from there up is the kept part.
    neg       = ~zero_bits + TILE_COUNT'(1);
    lowest    = zero_bits & neg;

    low_idx = '0;
    for (int i = 0; i < TILE_COUNT; i++) begin
      if (lowest[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end

    if (!compress) begin
      keep = '1;
      kept = KEPT_W'(TILE_COUNT);
    end else if (zero_bits == '0) begin
      // No zero at all: only the first element survives.
      keep = '0;
      keep[TILE_COUNT-1] = 1'b1;
      kept = KEPT_W'(1);
    end else begin
      keep = zero_bits | neg;
      kept = KEPT_W'(TILE_COUNT) - KEPT_W'(low_idx);
    end

    total = TOT_W'(kept) + TOT_W'(HDR_BITS);
    raw   = {window, 1'b0, bm, {PAD_W{1'b0}}};
    mask  = {{HDR_BITS{1'b1}}, keep, {PAD_W{1'b0}}};
    fill  = compress ? ~mask : '0;
    hdr   = ((BYTE_W'(window) << HDR_W_SHIFT) & HDR_W_MASK) | HDR_C_BIT;

    if (all_received) begin
      stream = {hdr, {(STREAM_W - BYTE_W){1'b0}}};
      nbytes = CNT_W'(1);
    end else begin
      stream = (raw & mask) | fill;
      // An aligned stream still gets a whole pad byte.
      nbytes = CNT_W'(total >> 3) + CNT_W'(1);
    end
  end

endmodule

FILE: src/fab_serializer.sv
// ============================================================================
// fab_serializer: frame register and byte shifter
// Holds one built frame and hands it out one byte per output transaction.
// ============================================================================
module fab_serializer
  import fab_pkg::*;
#(
  parameter int  TILE_COUNT   = TILE_COUNT_DEFAULT,
  localparam int STREAM_BYTES = (TILE_COUNT + HDR_BITS) / 8 + 1,
  localparam int STREAM_W     = STREAM_BYTES * BYTE_W,
  localparam int CNT_W        = $clog2(STREAM_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  logic [STREAM_W-1:0] load_stream,
  input  logic [CNT_W-1:0]    load_nbytes,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   data_byte,
  output logic                last_byte
);

  logic                f_valid;
  logic [STREAM_W-1:0] f_stream;
  logic [CNT_W-1:0]    f_count;

  assign out_valid  = f_valid;
  assign data_byte  = f_stream[STREAM_W-1 -: BYTE_W];
  assign last_byte  = (f_count == CNT_W'(1));
  assign load_ready = !f_valid || (out_ready && last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      f_count <= '0;
    end else if (load_ready) begin
      f_valid <= load_valid;
      if (load_valid) begin
        f_stream <= load_stream;
        f_count  <= load_nbytes;
      end
    end else if (out_ready) begin
      f_stream <= f_stream << BYTE_W;
      f_count  <= f_count - CNT_W'(1);
    end
  end

endmodule

FILE: src/fragment_ack_bitmap_encoder_top.sv
// ============================================================================
// fragment_ack_bitmap_encoder_top: acknowledgement bitmap encoder
// Accepts acknowledgement requests and streams the encoded bytes, MSB first.
// ============================================================================
// Each input transaction describes one acknowledgement and yields one output
// transaction per byte, the final one flagged by last_byte. With
// all_received set the answer is the single header byte window<<6 | 0x20.
// Otherwise the bit stream is the window number, a zero C bit and the bitmap
// (element 0 in the most significant used bitmap bit), sent whole with zero
// padding or, with compress set, cut after the last zero element (after
// element 0 if there is none) and padded with ones; the pad always adds
// one to eight bits, so an aligned stream still gets a full pad byte.
// Bitmap bits at or above TILE_COUNT are ignored. The byte count is one
// for the header-only form and (kept + 3) / 8 + 1 otherwise, nine for a
// full 63-element window. The output byte shifter moves one byte per
// cycle while out_ready is high. A request passes through the input
// register before its frame is loaded into the frame register, which
// presents the first byte. While a frame drains, the next request waits
// in the input register and its frame is built and loaded in the same
// cycle that the last byte of the current frame is taken, so bytes leave
// without gaps.
// ============================================================================
module fragment_ack_bitmap_encoder_top
  import fab_pkg::*;
#(
  parameter int TILE_COUNT = TILE_COUNT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WINDOW_W-1:0] window,
  input  logic                all_received,
  input  logic                compress,
  input  logic [BITMAP_W-1:0] bitmap,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   data_byte,
  output logic                last_byte
);

  localparam int STREAM_BYTES = (TILE_COUNT + HDR_BITS) / 8 + 1;
  localparam int STREAM_W     = STREAM_BYTES * BYTE_W;
  localparam int CNT_W        = $clog2(STREAM_BYTES + 1);

  // Input register: holds one accepted request until the frame register
  // can take its encoded form.
  logic                hold_valid;
  logic [WINDOW_W-1:0] hold_window;
  logic                hold_all_received;
  logic                hold_compress;
  logic [BITMAP_W-1:0] hold_bitmap;

  logic                load_ready;
  logic [STREAM_W-1:0] enc_stream;
  logic [CNT_W-1:0]    enc_nbytes;

  // The input register frees up whenever its content moves on, so a new
  // request can be accepted in the same cycle.
  assign in_ready = !hold_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_window       <= window;
      hold_all_received <= all_received;
      hold_compress     <= compress;
      hold_bitmap       <= bitmap;
    end
  end

  // Frame building is purely combinational from the input register.
  fab_encode #(
    .TILE_COUNT (TILE_COUNT)
  ) u_encode (
    .window       (hold_window),
    .all_received (hold_all_received),
    .compress     (hold_compress),
    .bitmap       (hold_bitmap),
    .stream       (enc_stream),
    .nbytes       (enc_nbytes)
  );

  // The frame register doubles as the output register.
  fab_serializer #(
    .TILE_COUNT (TILE_COUNT)
  ) u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (hold_valid),
    .load_ready  (load_ready),
    .load_stream (enc_stream),
    .load_nbytes (enc_nbytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte)
  );

  // An accepted request always lands in the input register.
  a_hold_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> hold_valid)
    else $error("accepted request did not reach the input register");

  // A request handed to the frame register shows up at the output next cycle.
  a_frame_load: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && load_ready) |=> out_valid)
    else $error("loaded frame not presented at the output");

  // A header-only acknowledgement is a single, final byte.
  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && load_ready && hold_all_received) |=> (out_valid && last_byte))
    else $error("header-only acknowledgement not marked as last byte");

  // A frame keeps producing bytes until its last one is taken.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_byte) |=> out_valid)
    else $error("frame ended before its last byte");

endmodule
